@@ design/assert_macros.svh @@
// concurrent assertion helpers, clocked on clk and off during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define SFD_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// consequent must hold at the same edge as the antecedent
`define SFD_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent must hold at the edge after the antecedent
`define SFD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/sfd_pkg.sv @@
package sfd_pkg;

	localparam logic [7:0] SYNC_FIRST_RST   = 8'h55;
	localparam logic [7:0] SYNC_SECOND_RST  = 8'hAA;
	localparam logic [7:0] SYNC_COMMAND_RST = 8'h88;

	// body bytes are frame bytes 3..7, position 4 is the checksum byte
	localparam logic [2:0] BODY_LAST = 3'd4;
	localparam logic [1:0] HIST_FULL = 2'd2;

	localparam logic REQ_BYTE  = 1'b0;
	localparam logic REQ_CLEAR = 1'b1;

	typedef enum logic [1:0] {
		CFG_SYNC_FIRST   = 2'd0,
		CFG_SYNC_SECOND  = 2'd1,
		CFG_SYNC_COMMAND = 2'd2
	} sfd_cfg_idx_t;

	typedef struct packed {
		logic [7:0]  status_byte;
		logic [7:0]  spare_byte;
		logic [15:0] distance_value;
		logic [7:0]  received_sum;
		logic        sum_matches;
	} sfd_result_t;

endpackage

@@ design/sfd_core.sv @@
`include "assert_macros.svh"

module sfd_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [7:0]          cfg_wdata,
	input  logic                valid_s1,
	input  logic                req_s1,
	input  logic [7:0]          byte_s1,
	output logic                res_valid,
	output sfd_pkg::sfd_result_t res_data
);
	import sfd_pkg::*;

	logic [7:0] sync_first_q;
	logic [7:0] sync_second_q;
	logic [7:0] sync_command_q;

	logic [7:0] hist0_q;
	logic [7:0] hist1_q;
	logic [1:0] hist_cnt_q;
	logic       in_frame_q;
	logic [2:0] pos_q;
	logic [7:0] sum_q;
	logic [7:0] held0_q;
	logic [7:0] held1_q;
	logic [7:0] held2_q;

	logic is_byte;
	logic hdr_hit;
	logic last_byte;

	assign is_byte   = valid_s1 && (req_s1 == REQ_BYTE);
	assign hdr_hit   = (hist_cnt_q == HIST_FULL) && (hist0_q == sync_first_q) &&
		(hist1_q == sync_second_q) && (byte_s1 == sync_command_q);
	assign last_byte = in_frame_q && (pos_q == BODY_LAST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_first_q   <= SYNC_FIRST_RST;
			sync_second_q  <= SYNC_SECOND_RST;
			sync_command_q <= SYNC_COMMAND_RST;
		end else if (cfg_we) begin
			case (sfd_cfg_idx_t'(cfg_index))
				CFG_SYNC_FIRST:   sync_first_q   <= cfg_wdata;
				CFG_SYNC_SECOND:  sync_second_q  <= cfg_wdata;
				CFG_SYNC_COMMAND: sync_command_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist0_q    <= '0;
			hist1_q    <= '0;
			hist_cnt_q <= '0;
			in_frame_q <= 1'b0;
			pos_q      <= '0;
			sum_q      <= '0;
		end else if (valid_s1) begin
			if (req_s1 == REQ_CLEAR) begin
				hist0_q    <= '0;
				hist1_q    <= '0;
				hist_cnt_q <= '0;
				in_frame_q <= 1'b0;
				pos_q      <= '0;
				sum_q      <= '0;
			end else if (!in_frame_q) begin
				if (hdr_hit) begin
					in_frame_q <= 1'b1;
					pos_q      <= '0;
					sum_q      <= sync_first_q + sync_second_q + sync_command_q;
					hist0_q    <= '0;
					hist1_q    <= '0;
					hist_cnt_q <= '0;
				end else begin
					hist0_q <= hist1_q;
					hist1_q <= byte_s1;
					if (hist_cnt_q != HIST_FULL) begin
						hist_cnt_q <= hist_cnt_q + 2'd1;
					end
				end
			end else if (!last_byte) begin
				// frame byte 6 parks in the first history slot
				if (pos_q == 3'd3) begin
					hist0_q <= byte_s1;
				end
				sum_q <= sum_q + byte_s1;
				pos_q <= pos_q + 3'd1;
			end else begin
				in_frame_q <= 1'b0;
				pos_q      <= '0;
				sum_q      <= '0;
				hist0_q    <= '0;
				hist1_q    <= '0;
				hist_cnt_q <= '0;
			end
		end
	end

	// status, spare and distance high byte, written only inside a frame
	always_ff @(posedge clk) begin
		if (is_byte && in_frame_q) begin
			case (pos_q)
				3'd0:    held0_q <= byte_s1;
				3'd1:    held1_q <= byte_s1;
				3'd2:    held2_q <= byte_s1;
				default: ;
			endcase
		end
	end

	assign res_valid               = is_byte && last_byte;
	assign res_data.status_byte    = held0_q;
	assign res_data.spare_byte     = held1_q;
	assign res_data.distance_value = {held2_q, hist0_q};
	assign res_data.received_sum   = byte_s1;
	assign res_data.sum_matches    = (sum_q == byte_s1);

	`SFD_ASSERT(a_pos_range, pos_q <= BODY_LAST, "frame position past checksum byte")
	`SFD_ASSERT_IMP(a_hunt_pos, !in_frame_q, pos_q == '0 && sum_q == '0,
		"position not zero while hunting")
	`SFD_ASSERT_IMP(a_frame_hist, in_frame_q, hist_cnt_q == '0 && hist1_q == '0,
		"history kept while collecting a frame")
	`SFD_ASSERT_NEXT(a_end_hunt, res_valid, !in_frame_q && hist_cnt_q == '0,
		"frame end did not return to hunting")

endmodule

@@ design/sfd_out_buf.sv @@
`include "assert_macros.svh"

module sfd_out_buf (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  sfd_pkg::sfd_result_t push_data,
	input  logic                out_stall,
	output logic                out_valid,
	output sfd_pkg::sfd_result_t out_data,
	output logic [1:0]          occ
);
	import sfd_pkg::*;

	sfd_result_t slot0_q;
	sfd_result_t slot1_q;
	logic [1:0]  occ_q;
	logic [1:0]  occ_after;
	logic        pop;

	assign out_valid = (occ_q != 2'd0);
	assign out_data  = slot0_q;
	assign occ       = occ_q;
	assign pop       = out_valid && !out_stall;
	assign occ_after = occ_q - {1'b0, pop};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else begin
			occ_q <= occ_after + {1'b0, push};
		end
	end

	always_ff @(posedge clk) begin
		if (push && (occ_after == 2'd0)) begin
			slot0_q <= push_data;
		end else if (pop) begin
			slot0_q <= slot1_q;
		end
		if (push && (occ_after != 2'd0)) begin
			slot1_q <= push_data;
		end
	end

	`SFD_ASSERT(a_occ_range, occ_q <= 2'd2, "result buffer count out of range")
	`SFD_ASSERT_IMP(a_no_overflow, push, occ_after != 2'd2, "result pushed into full buffer")
	`SFD_ASSERT_NEXT(a_hold_head, out_valid && out_stall, out_valid && $stable(slot0_q),
		"stalled result changed")

endmodule

@@ design/sensor_frame_deframer.sv @@
// sensor frame deframer: takes a receive byte stream, one byte per item, hunts
// for the three-byte header (sync_first, sync_second, sync_command, reset
// 55 AA 88) and then collects five more bytes into an 8-byte frame. at frame
// byte 7 one result item comes out with status, spare, big-endian distance,
// the checksum as sent and whether the low byte of the sum of bytes 0..6
// matches it. a clear item (req_type = 1) drops all frame and history state.
// rate: one item per cycle sustained while in_stall is low. an accepted item
// is held in the input register, is decoded in a single pass, and its result
// lands in a two-deep output buffer the next edge and is offered from there.
// in_stall rises when that buffer is full, or when it holds one result and
// the item in the input register closes another frame; both only happen
// while out_stall holds results back, since frames are eight items apart.
// configuration registers (cfg_index 0..2) are written with cfg_we; an index
// of 3 is ignored. write them only while no item is in flight.
module sensor_frame_deframer (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_wdata,
	// input items
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        req_type,
	input  logic [7:0]  rx_byte,
	// result items
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  status_byte,
	output logic [7:0]  spare_byte,
	output logic [15:0] distance_value,
	output logic [7:0]  received_sum,
	output logic        sum_matches
);
	import sfd_pkg::*;

	// input register
	logic        valid_s1;
	logic        req_s1;
	logic [7:0]  byte_s1;

	logic        in_take;
	logic        res_valid;
	sfd_result_t res_data;
	sfd_result_t out_data;
	logic [1:0]  occ;

	// room check: buffered results plus the result of the item in the input register
	assign in_stall = (occ == 2'd2) || ((occ == 2'd1) && res_valid);
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_take;
		end
	end

	// payload needs no reset, only loaded on accept
	always_ff @(posedge clk) begin
		if (in_take) begin
			req_s1  <= req_type;
			byte_s1 <= rx_byte;
		end
	end

	// header hunt, frame collection and checksum
	sfd_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.valid_s1  (valid_s1),
		.req_s1    (req_s1),
		.byte_s1   (byte_s1),
		.res_valid (res_valid),
		.res_data  (res_data)
	);

	// result register with skid slot
	sfd_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res_data),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_data  (out_data),
		.occ       (occ)
	);

	assign status_byte    = out_data.status_byte;
	assign spare_byte     = out_data.spare_byte;
	assign distance_value = out_data.distance_value;
	assign received_sum   = out_data.received_sum;
	assign sum_matches    = out_data.sum_matches;

endmodule

@@ verif/tb_top.sv @@
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import sfd_pkg::*;

	// unused register slot, writes there must leave the header alone
	localparam logic [1:0]  CFG_NO_REG   = 2'd3;
	localparam int unsigned NUM_PHASES   = 6;
	localparam int unsigned PHASE_ITEMS  = 260;
	localparam int unsigned LONG_HOLD    = 300;
	localparam int unsigned DRAIN_CYCLES = 6;
	localparam int unsigned DRAIN_GUARD  = 20000;

	// frame predictor and result check in one place
	class deframe_checker;
		localparam int unsigned REPORT_LIMIT = 10;

		// header registers as the block should hold them
		logic [7:0]  sync_b0, sync_b1, sync_cmd;
		// hunting history, oldest byte first
		logic [7:0]  hist_old, hist_new;
		int unsigned hist_cnt;
		// frame collection
		bit          collecting;
		int unsigned body_pos;
		logic [7:0]  sum_acc;
		logic [7:0]  held_status, held_spare, held_dist_hi, held_dist_lo;
		sfd_result_t frames_due[$];
		int unsigned faults, frames_seen, bad_sums, items_taken, clears_taken;

		function new();
			sync_b0 = SYNC_FIRST_RST;
			sync_b1 = SYNC_SECOND_RST;
			sync_cmd = SYNC_COMMAND_RST;
			faults = 0;
			frames_seen = 0;
			bad_sums = 0;
			items_taken = 0;
			clears_taken = 0;
			drop_frame();
		endfunction

		function void drop_frame();
			hist_old = 8'h00;
			hist_new = 8'h00;
			hist_cnt = 0;
			collecting = 1'b0;
			body_pos = 0;
			sum_acc = 8'h00;
			held_status = 8'h00;
			held_spare = 8'h00;
			held_dist_hi = 8'h00;
			held_dist_lo = 8'h00;
		endfunction

		function void set_reg(logic [1:0] idx, logic [7:0] val);
			case (idx)
				CFG_SYNC_FIRST:   sync_b0 = val;
				CFG_SYNC_SECOND:  sync_b1 = val;
				CFG_SYNC_COMMAND: sync_cmd = val;
				default: ;
			endcase
		endfunction

		function int unsigned pending();
			return frames_due.size();
		endfunction

		// one accepted input item, queues the frame result it completes
		function void take_item(logic kind, logic [7:0] data);
			sfd_result_t res;
			items_taken++;
			if (kind == REQ_CLEAR) begin
				clears_taken++;
				drop_frame();
				return;
			end
			if (!collecting) begin
				// header needs two real history bytes, not the cleared zeros
				if (hist_cnt >= HIST_FULL && hist_old == sync_b0 &&
						hist_new == sync_b1 && data == sync_cmd) begin
					collecting = 1'b1;
					body_pos = 0;
					sum_acc = sync_b0 + sync_b1 + sync_cmd;
					hist_old = 8'h00;
					hist_new = 8'h00;
					hist_cnt = 0;
				end else begin
					hist_old = hist_new;
					hist_new = data;
					if (hist_cnt < HIST_FULL)
						hist_cnt++;
				end
				return;
			end
			if (body_pos < BODY_LAST) begin
				case (body_pos)
					0: held_status = data;
					1: held_spare = data;
					2: held_dist_hi = data;
					default: held_dist_lo = data;
				endcase
				sum_acc += data;
				body_pos++;
				return;
			end
			// checksum byte closes the frame
			res.status_byte = held_status;
			res.spare_byte = held_spare;
			res.distance_value = {held_dist_hi, held_dist_lo};
			res.received_sum = data;
			res.sum_matches = (sum_acc == data);
			frames_due.insert(frames_due.size(), res);
			drop_frame();
		endfunction

		function void check_frame(sfd_result_t got);
			sfd_result_t want;
			if (frames_due.size() == 0) begin
				faults++;
				if (faults <= REPORT_LIMIT)
					$display("extra result: status %h spare %h dist %h sum %h match %b",
						got.status_byte, got.spare_byte, got.distance_value,
						got.received_sum, got.sum_matches);
				return;
			end
			want = frames_due.pop_front();
			frames_seen++;
			if (!want.sum_matches)
				bad_sums++;
			if (got.status_byte !== want.status_byte ||
					got.spare_byte !== want.spare_byte ||
					got.distance_value !== want.distance_value ||
					got.received_sum !== want.received_sum ||
					got.sum_matches !== want.sum_matches) begin
				faults++;
				if (faults <= REPORT_LIMIT) begin
					$display("frame %0d exp: st %h sp %h dist %h sum %h match %b",
						frames_seen, want.status_byte, want.spare_byte,
						want.distance_value, want.received_sum, want.sum_matches);
					$display("frame %0d got: st %h sp %h dist %h sum %h match %b",
						frames_seen, got.status_byte, got.spare_byte,
						got.distance_value, got.received_sum, got.sum_matches);
				end
			end
		endfunction

		function void close_out();
			if (frames_due.size() != 0) begin
				faults += frames_due.size();
				$display("%0d frame results never came out", frames_due.size());
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [7:0]  cfg_wdata;
	logic        in_valid;
	logic        in_stall;
	logic        req_type;
	logic [7:0]  rx_byte;
	logic        out_valid;
	logic        out_stall;
	logic [7:0]  status_byte;
	logic [7:0]  spare_byte;
	logic [15:0] distance_value;
	logic [7:0]  received_sum;
	logic        sum_matches;

	deframe_checker sb;
	sfd_result_t    out_frame;

	// idle percentages per side, changed between phases
	int unsigned send_idle;
	int unsigned recv_idle;
	// asks the receiver for one long hold-off
	bit          hold_req;
	int unsigned items_sent;

	sensor_frame_deframer dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.req_type       (req_type),
		.rx_byte        (rx_byte),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status_byte    (status_byte),
		.spare_byte     (spare_byte),
		.distance_value (distance_value),
		.received_sum   (received_sum),
		.sum_matches    (sum_matches)
	);

	// 10 ns clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// watch both handshakes on pre-edge values
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.take_item(req_type, rx_byte);
			if (out_valid && !out_stall) begin
				out_frame.status_byte = status_byte;
				out_frame.spare_byte = spare_byte;
				out_frame.distance_value = distance_value;
				out_frame.received_sum = received_sum;
				out_frame.sum_matches = sum_matches;
				sb.check_frame(out_frame);
			end
		end
	end

	// result side back-pressure: random stalls, or one long counted hold-off
	initial begin : stall_gen
		int unsigned n;
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				for (n = 0; n < LONG_HOLD; n++) begin
					out_stall <= 1'b1;
					@(posedge clk);
				end
			end else begin
				out_stall <= ($urandom_range(99) < recv_idle);
				@(posedge clk);
			end
		end
	end

	// hard stop in case the block hangs
	initial begin
		#5ms;
		$display("timeout waiting for the deframer");
		$display("FAILURE");
		$finish;
	end

	// mostly random bytes, with the two extremes showing up often
	function automatic logic [7:0] pick_byte();
		case ($urandom_range(9))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	// offer one item after a random gap, return once it is taken
	task automatic send_item(input logic kind, input logic [7:0] data);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= kind;
		rx_byte <= data;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic send_byte(input logic [7:0] data);
		send_item(REQ_BYTE, data);
	endtask

	// clear carries a random byte that must be ignored
	task automatic send_clear();
		send_item(REQ_CLEAR, 8'($urandom_range(255)));
	endtask

	// header with the current registers, four random body bytes, then checksum
	task automatic send_frame(input bit good_sum);
		logic [7:0] acc;
		logic [7:0] b;
		int i;
		acc = sb.sync_b0 + sb.sync_b1 + sb.sync_cmd;
		send_byte(sb.sync_b0);
		send_byte(sb.sync_b1);
		send_byte(sb.sync_cmd);
		for (i = 0; i < 4; i++) begin
			b = pick_byte();
			acc += b;
			send_byte(b);
		end
		send_byte(good_sum ? acc : pick_byte());
	endtask

	// stop offering, wait out every queued result and the pipeline tail
	task automatic settle();
		int unsigned guard;
		guard = 0;
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0 && guard < DRAIN_GUARD) begin
			@(posedge clk);
			guard++;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		sb.set_reg(idx, val);
	endtask

	// all three header registers plus a write to the empty slot
	task automatic load_header(input logic [7:0] b0, input logic [7:0] b1,
			input logic [7:0] b2);
		write_reg(CFG_NO_REG, 8'($urandom_range(255)));
		write_reg(CFG_SYNC_FIRST, b0);
		write_reg(CFG_SYNC_SECOND, b1);
		write_reg(CFG_SYNC_COMMAND, b2);
		cfg_we <= 1'b0;
	endtask

	// one random sequence: mostly clean frames, some noise and broken ones
	task automatic random_burst();
		int unsigned roll;
		int unsigned n;
		int unsigned i;
		roll = $urandom_range(99);
		if (roll < 68) begin
			send_frame($urandom_range(99) < 65);
		end else if (roll < 80) begin
			// noise, salted with header bytes so false starts happen
			n = $urandom_range(1, 4);
			for (i = 0; i < n; i++) begin
				case ($urandom_range(4))
					0: send_byte(sb.sync_b0);
					1: send_byte(sb.sync_b1);
					2: send_byte(sb.sync_cmd);
					default: send_byte(pick_byte());
				endcase
			end
		end else if (roll < 88) begin
			// header cut short
			send_byte(sb.sync_b0);
			if ($urandom_range(1))
				send_byte(sb.sync_b1);
			send_byte(pick_byte());
		end else if (roll < 95) begin
			// frame abandoned by a clear
			send_byte(sb.sync_b0);
			send_byte(sb.sync_b1);
			send_byte(sb.sync_cmd);
			n = $urandom_range(0, 4);
			repeat (n) send_byte(pick_byte());
			send_clear();
		end else begin
			send_clear();
		end
	endtask

	initial begin
		int unsigned ph;
		int unsigned target;

		// every input known from time zero
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_SYNC_FIRST;
		cfg_wdata = 8'h00;
		in_valid = 1'b0;
		req_type = REQ_BYTE;
		rx_byte = 8'h00;
		hold_req = 1'b0;
		items_sent = 0;
		send_idle = 21;
		recv_idle = 67;
		sb = new();

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: all-zero body with good checksum at reset header
		send_byte(8'h55); send_byte(8'hAA); send_byte(8'h88);
		repeat (4) send_byte(8'h00);
		send_byte(8'h87);
		// all-ones body with a wrong checksum, no resync expected
		send_byte(8'h55); send_byte(8'hAA); send_byte(8'h88);
		repeat (5) send_byte(8'hFF);
		// clear wipes the history, so the command byte alone finds nothing
		send_byte(8'h55); send_byte(8'hAA); send_clear(); send_byte(8'h88);
		// header after a doubled first sync byte, header bytes then sit in the body
		send_byte(8'h55); send_byte(8'h55); send_byte(8'hAA); send_byte(8'h88);
		send_byte(8'h55);
		// registers change mid-frame, the frame keeps its old header sum
		settle();
		load_header(8'h00, 8'h00, 8'h00);
		send_byte(8'hAA); send_byte(8'h88); send_byte(8'h00); send_byte(8'h0F);
		settle();

		// random phases, each with its own header and idle mix
		for (ph = 0; ph < NUM_PHASES; ph++) begin
			case (ph)
				0: load_header(SYNC_FIRST_RST, SYNC_SECOND_RST, SYNC_COMMAND_RST);
				1: load_header(8'h00, 8'h00, 8'h00);
				2: load_header(8'hFF, 8'hFF, 8'hFF);
				5: load_header(SYNC_FIRST_RST, SYNC_SECOND_RST, SYNC_COMMAND_RST);
				default: load_header(8'($urandom_range(255)), 8'($urandom_range(255)),
					8'($urandom_range(255)));
			endcase
			if (ph < 2) begin
				send_idle = 21;
				recv_idle = 67;
			end else if (ph < 4) begin
				send_idle = 67;
				recv_idle = 21;
			end else begin
				send_idle = 0;
				recv_idle = 0;
			end
			// long receiver hold while the sender keeps pushing at full rate
			if (ph == 4)
				hold_req = 1'b1;
			target = items_sent + PHASE_ITEMS;
			while (items_sent < target)
				random_burst();
			settle();
		end

		sb.close_out();
		$display("run: %0d items, %0d clears, %0d frames checked, %0d bad checksums",
			sb.items_taken, sb.clears_taken, sb.frames_seen, sb.bad_sums);
		$display("headers reset, zero, ones, random; mid-frame rewrite; %0d-cycle hold",
			LONG_HOLD);
		if (sb.faults == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

@@ sensor_frame_deframer.f @@
+incdir+design
design/sfd_pkg.sv
design/sfd_core.sv
design/sfd_out_buf.sv
design/sensor_frame_deframer.sv
verif/tb_top.sv
